// ----- sv/rvrp_pkg.sv -----
package rvrp_pkg;

    localparam int DEFAULT_MAX_ITEMS = 14;
    localparam int ITEM_W = 4;

    typedef enum logic [3:0] {
        K_SOURCE    = 4'd0,
        K_TYPE      = 4'd1,
        K_QUAL      = 4'd2,
        K_POLAR     = 4'd3,
        K_CART      = 4'd4,
        K_WEATHER   = 4'd5,
        K_CONTOUR   = 4'd6,
        K_POINT     = 4'd7,
        K_TIME      = 4'd8,
        K_STATUS    = 4'd9,
        K_STATION   = 4'd10,
        K_TOTAL     = 4'd11,
        K_ERROR     = 4'd12
    } kind_t;

    localparam logic [23:0] ERR_CLOSED  = 24'd0;
    localparam logic [23:0] ERR_MISSING = 24'd1;
    localparam logic [23:0] ERR_TYPE    = 24'd2;
    localparam logic [23:0] ERR_EARLY   = 24'd3;

    localparam logic [2:0] CFG_POLAR   = 3'd0;
    localparam logic [2:0] CFG_CART    = 3'd1;
    localparam logic [2:0] CFG_CONTOUR = 3'd2;
    localparam logic [2:0] CFG_WEATHER = 3'd3;
    localparam logic [2:0] CFG_SOP     = 3'd4;
    localparam logic [2:0] CFG_EOP     = 3'd5;

    localparam logic [2:0] TYPE_BAD = 3'd6;

    typedef struct packed {
        logic [3:0]  kind;
        logic [23:0] value_a;
        logic [7:0]  value_b;
        logic [7:0]  value_c;
        logic [7:0]  value_d;
        logic        last_element;
        logic        record_done;
    } result_t;

    function automatic logic [13:0] mand_mask(input logic [2:0] t);
        case (t)
            3'd0: mand_mask = 14'h0380;
            3'd1: mand_mask = 14'h0680;
            3'd2: mand_mask = 14'h000C;
            3'd3: mand_mask = 14'h0804;
            3'd4: mand_mask = 14'h0014;
            3'd5: mand_mask = 14'h0060;
            default: mand_mask = 14'h0000;
        endcase
    endfunction

    function automatic result_t mk_res(input logic [3:0] k, input logic [23:0] a,
                                       input logic [7:0] b, input logic [7:0] c,
                                       input logic [7:0] d, input logic l);
        mk_res = '{kind: k, value_a: a, value_b: b, value_c: c, value_d: d,
                   last_element: l, record_done: 1'b0};
    endfunction

endpackage

// ----- sv/radar_vector_record_parser.sv -----
// Weather-vector radar record parser.
// Input channel (s_valid/s_ready): one record octet per request, s_record_end
// on the last octet. Output channel (m_valid/m_ready): decoded fields, one
// result per request, m_record_done on the last result of a record.
// Configuration: cfg_we/cfg_index/cfg_data writes a message type code,
// taken at once; write only while idle.
// Throughput: one octet per cycle while each octet gives at most one
// result and the queue has space; an octet giving more than one result
// blocks input while the front stage drains them into the result queue.
// Each result is registered in the front's pending buffer, then in the queue.
// A four-entry queue separates the front from the output, so the front
// keeps accepting while the receiver stalls until the queue fills.
// Reset (aresetn low, synchronous) empties the queue, restarts the record
// and restores the default type codes.
module radar_vector_record_parser
    import rvrp_pkg::*;
#(
    parameter int MAX_ITEMS = DEFAULT_MAX_ITEMS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_record_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_kind,
    output logic [23:0] m_value_a,
    output logic [7:0]  m_value_b,
    output logic [7:0]  m_value_c,
    output logic [7:0]  m_value_d,
    output logic        m_last_element,
    output logic        m_record_done,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0] c_pol_reg, c_cart_reg, c_con_reg, c_wea_reg, c_sop_reg, c_eop_reg;
    logic       q_push, q_space;
    result_t    q_in, q_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_pol_reg <= 8'd1; c_cart_reg <= 8'd2; c_con_reg <= 8'd3;
            c_wea_reg <= 8'd4; c_sop_reg <= 8'd254; c_eop_reg <= 8'd255;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_POLAR:   c_pol_reg  <= cfg_data;
                CFG_CART:    c_cart_reg <= cfg_data;
                CFG_CONTOUR: c_con_reg  <= cfg_data;
                CFG_WEATHER: c_wea_reg  <= cfg_data;
                CFG_SOP:     c_sop_reg  <= cfg_data;
                CFG_EOP:     c_eop_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    rvrp_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .in_byte(s_data_byte), .in_end(s_record_end),
        .code_polar(c_pol_reg), .code_cartesian(c_cart_reg),
        .code_contour(c_con_reg), .code_weather(c_wea_reg),
        .code_sop(c_sop_reg), .code_eop(c_eop_reg),
        .q_push(q_push), .q_space(q_space), .q_data(q_in)
    );

    rvrp_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .space(q_space), .push_data(q_in),
        .out_valid(m_valid), .out_ready(m_ready), .out_data(q_out)
    );

    assign m_kind         = q_out.kind;
    assign m_value_a      = q_out.value_a;
    assign m_value_b      = q_out.value_b;
    assign m_value_c      = q_out.value_c;
    assign m_value_d      = q_out.value_d;
    assign m_last_element = q_out.last_element;
    assign m_record_done  = q_out.record_done;

endmodule

// ----- sv/rvrp_front.sv -----
module rvrp_front
    import rvrp_pkg::*;
#(
    parameter int MAX_ITEMS = DEFAULT_MAX_ITEMS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_end,
    input  logic [7:0]  code_polar,
    input  logic [7:0]  code_cartesian,
    input  logic [7:0]  code_contour,
    input  logic [7:0]  code_weather,
    input  logic [7:0]  code_sop,
    input  logic [7:0]  code_eop,
    output logic        q_push,
    input  logic        q_space,
    output result_t     q_data
);

    typedef enum logic [4:0] {
        PH_FSPEC1 = 5'b00001,
        PH_FSPEC2 = 5'b00010,
        PH_FMORE  = 5'b00100,
        PH_ITEM   = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    localparam logic [13:0] ITEM_MASK = 14'((15'd1 << MAX_ITEMS) - 15'd1);

    // byte is processed once; its results drain one per cycle while the queue has space
    phase_t      phase_reg, phase_next;
    logic [13:0] pres_reg, pres_next;
    logic [7:0]  code_reg, code_next;
    logic [3:0]  item_reg, item_next;
    logic [2:0]  bii_reg, bii_next;
    logic [7:0]  rep_reg, rep_next;
    logic [23:0] asm_reg, asm_next;
    logic [7:0]  skip_reg, skip_next;

    // pending results of the current byte
    result_t     pend_reg [6];
    logic [2:0]  pcnt_reg, pidx_reg;
    logic        busy_reg;

    result_t     res [6];
    logic [2:0]  cnt;

    function automatic logic [2:0] tindex(input logic [7:0] c, input logic [7:0] sop,
            input logic [7:0] eop, input logic [7:0] ca, input logic [7:0] we,
            input logic [7:0] po, input logic [7:0] co);
        if (c == sop) tindex = 3'd0;
        else if (c == eop) tindex = 3'd1;
        else if (c == ca) tindex = 3'd2;
        else if (c == we) tindex = 3'd3;
        else if (c == po) tindex = 3'd4;
        else if (c == co) tindex = 3'd5;
        else tindex = TYPE_BAD;
    endfunction

    // next request may enter while the last pending result is pushed
    assign in_ready = !busy_reg || (q_space && (pidx_reg + 3'd1 == pcnt_reg));

    always_comb begin
        logic [13:0] mm;
        logic [2:0]  t;
        logic [23:0] v;
        logic [7:0]  f;
        logic [3:0]  first;
        logic        do_adv, found, last;
        logic [2:0]  elen;
        phase_next = phase_reg;
        pres_next  = pres_reg;
        code_next  = code_reg;
        item_next  = item_reg;
        bii_next   = bii_reg;
        rep_next   = rep_reg;
        asm_next   = asm_reg;
        skip_next  = skip_reg;
        cnt = 3'd0;
        for (int r = 0; r < 6; r++) res[r] = '0;
        do_adv = 1'b0;
        first  = 4'd1;
        mm = '0; t = '0; v = '0; f = '0; found = 1'b0; last = 1'b0; elen = '0;

        unique case (phase_reg)
            PH_FSPEC1: begin
                pres_next = (pres_reg | {7'd0, in_byte[1], in_byte[2], in_byte[3],
                             in_byte[4], in_byte[5], in_byte[6], in_byte[7]}) & ITEM_MASK;
                if (in_byte[0]) phase_next = PH_FSPEC2;
                else do_adv = 1'b1;
            end
            PH_FSPEC2: begin
                pres_next = (pres_reg | {in_byte[1], in_byte[2], in_byte[3], in_byte[4],
                             in_byte[5], in_byte[6], in_byte[7], 7'd0}) & ITEM_MASK;
                if (in_byte[0]) phase_next = PH_FMORE;
                else do_adv = 1'b1;
            end
            PH_FMORE: begin
                if (!in_byte[0]) do_adv = 1'b1;
            end
            PH_ITEM: begin
                case (item_reg)
                    4'd1, 4'd6, 4'd8, 4'd11: begin
                        if ({1'b0, bii_reg} + 4'd1 < ((item_reg == 4'd8) ? 4'd3 : 4'd2)) begin
                            asm_next = {asm_reg[15:0], in_byte};
                            bii_next = bii_reg + 3'd1;
                        end else begin
                            v = {asm_reg[15:0], in_byte};
                            if (item_reg == 4'd1)
                                res[0] = mk_res(K_SOURCE, {16'd0, v[15:8]}, v[7:0], 8'd0,
                                                8'd0, 1'b0);
                            else if (item_reg == 4'd6)
                                res[0] = mk_res(K_CONTOUR, {16'd0, v[7:0]}, {7'd0, v[15]},
                                                {5'd0, v[14:12]}, {6'd0, v[9:8]}, 1'b0);
                            else if (item_reg == 4'd8)
                                res[0] = mk_res(K_TIME, {7'd0, v[23:7]}, 8'd0, 8'd0, 8'd0,
                                                1'b0);
                            else
                                res[0] = mk_res(K_TOTAL, {8'd0, v[15:0]}, 8'd0, 8'd0, 8'd0,
                                                1'b0);
                            cnt = 3'd1;
                            do_adv = 1'b1;
                            first = item_reg + 4'd1;
                        end
                    end
                    4'd2: begin
                        code_next = in_byte;
                        res[0] = mk_res(K_TYPE, {16'd0, in_byte}, 8'd0, 8'd0, 8'd0, 1'b0);
                        cnt = 3'd1;
                        if (tindex(in_byte, code_sop, code_eop, code_cartesian, code_weather,
                                   code_polar, code_contour) == TYPE_BAD) begin
                            res[1] = mk_res(K_ERROR, ERR_TYPE, in_byte, 8'd0, 8'd0, 1'b0);
                            cnt = 3'd2;
                            phase_next = PH_DONE;
                        end else begin
                            do_adv = 1'b1;
                            first = 4'd3;
                        end
                    end
                    4'd3: begin
                        v = asm_reg;
                        if (bii_reg == 3'd0) v = {8'd0, in_byte, 8'd0};
                        else if (bii_reg == 3'd1)
                            v = {8'd0, asm_reg[15:8], 6'd0, in_byte[2:1]};
                        asm_next = v;
                        if (in_byte[0]) begin
                            if (bii_reg < 3'd2) bii_next = bii_reg + 3'd1;
                        end else begin
                            f = v[15:8];
                            res[0] = mk_res(K_QUAL, {23'd0, f[7]}, {5'd0, f[6:4]},
                                            {5'd0, f[3:1]}, {6'd0, v[1:0]}, 1'b0);
                            cnt = 3'd1;
                            do_adv = 1'b1;
                            first = 4'd4;
                        end
                    end
                    4'd4, 4'd5, 4'd7, 4'd12: begin
                        elen = (item_reg == 4'd4) ? 3'd3 : (item_reg == 4'd7) ? 3'd2 : 3'd4;
                        if (bii_reg == 3'd0) begin
                            rep_next = in_byte;
                            asm_next = '0;
                            if (in_byte == 8'd0) begin
                                do_adv = 1'b1;
                                first = item_reg + 4'd1;
                            end else bii_next = 3'd1;
                        end else if (bii_reg < elen) begin
                            asm_next = {asm_reg[15:0], in_byte};
                            bii_next = bii_reg + 3'd1;
                        end else begin
                            v = asm_reg;
                            last = (rep_reg == 8'd1);
                            if (item_reg == 4'd4)
                                res[0] = mk_res(K_CART, {16'd0, v[15:8]}, v[7:0], in_byte,
                                                8'd0, last);
                            else if (item_reg == 4'd5)
                                res[0] = mk_res(K_POLAR, {8'd0, v[7:0], in_byte}, v[23:16],
                                                v[15:8], 8'd0, last);
                            else if (item_reg == 4'd7)
                                res[0] = mk_res(K_POINT, {16'd0, v[7:0]}, in_byte, 8'd0,
                                                8'd0, last);
                            else
                                res[0] = mk_res(K_WEATHER, {16'd0, v[23:16]}, v[15:8],
                                                v[7:0], in_byte, last);
                            cnt = 3'd1;
                            rep_next = rep_reg - 8'd1;
                            bii_next = 3'd1;
                            asm_next = '0;
                            if (rep_reg == 8'd1) begin
                                do_adv = 1'b1;
                                first = item_reg + 4'd1;
                            end
                        end
                    end
                    4'd9: begin
                        v = asm_reg;
                        if (bii_reg < 3'd3) begin
                            v = {asm_reg[15:0], in_byte};
                            asm_next = v;
                        end
                        if (bii_reg < 3'd2) bii_next = bii_reg + 3'd1;
                        else if (in_byte[0]) bii_next = 3'd3;
                        else begin
                            res[0] = mk_res(K_STATUS, {9'd0, v[15:1]}, {5'd0, v[18:16]},
                                            {4'd0, v[22:19]}, {7'd0, v[23]}, 1'b0);
                            cnt = 3'd1;
                            do_adv = 1'b1;
                            first = 4'd10;
                        end
                    end
                    4'd10: begin
                        res[0] = mk_res(K_STATION, {16'd0, in_byte}, 8'd0, 8'd0, 8'd0,
                                        !in_byte[0]);
                        cnt = 3'd1;
                        if (!in_byte[0]) begin
                            do_adv = 1'b1;
                            first = 4'd11;
                        end
                    end
                    4'd13, 4'd14: begin
                        if (bii_reg == 3'd0) begin
                            skip_next = (in_byte >= 8'd2) ? in_byte - 8'd1 : 8'd0;
                            if (in_byte < 8'd2) begin
                                do_adv = 1'b1;
                                first = item_reg + 4'd1;
                            end else bii_next = 3'd1;
                        end else begin
                            skip_next = skip_reg - 8'd1;
                            if (skip_reg == 8'd1) begin
                                do_adv = 1'b1;
                                first = item_reg + 4'd1;
                            end
                        end
                    end
                    default: phase_next = PH_DONE;
                endcase
            end
            default: phase_next = PH_DONE;
        endcase

        if (do_adv) begin
            if (first >= 4'd3) begin
                t = tindex(code_next, code_sop, code_eop, code_cartesian, code_weather,
                           code_polar, code_contour);
                mm = mand_mask(t);
            end
            found = 1'b0;
            phase_next = PH_DONE;
            for (int i = 1; i <= 14; i++) begin
                if (!found && 4'(i) >= first && phase_next != PH_ITEM) begin
                    if (pres_next[i-1]) begin
                        found = 1'b1;
                        phase_next = PH_ITEM;
                        item_next = 4'(i);
                        bii_next = '0;
                        rep_next = '0;
                        asm_next = '0;
                        skip_next = '0;
                    end else if (i <= 2 || mm[i-1]) begin
                        if (cnt < 3'd6) begin
                            res[cnt] = mk_res(K_ERROR, ERR_MISSING, 8'(i), 8'd0, 8'd0, 1'b0);
                            cnt = cnt + 3'd1;
                        end
                        if (i == 2) found = 1'b1;
                    end
                end
            end
        end

        if (in_end) begin
            if (phase_next == PH_ITEM) begin
                if (cnt < 3'd6) begin
                    res[cnt] = mk_res(K_ERROR, ERR_EARLY, {4'd0, item_next}, 8'd0, 8'd0, 1'b0);
                    cnt = cnt + 3'd1;
                end
            end else if (phase_next != PH_DONE) begin
                if (cnt < 3'd6) begin
                    res[cnt] = mk_res(K_ERROR, ERR_EARLY, 8'd0, 8'd0, 8'd0, 1'b0);
                    cnt = cnt + 3'd1;
                end
            end
            if (cnt == 3'd0) begin
                res[0] = mk_res(K_ERROR, ERR_CLOSED, 8'd0, 8'd0, 8'd0, 1'b0);
                cnt = 3'd1;
            end
            for (int r = 0; r < 6; r++)
                if (3'(r) == cnt - 3'd1) res[r].record_done = 1'b1;
            phase_next = PH_FSPEC1;
            pres_next = '0; code_next = '0; item_next = '0; bii_next = '0;
            rep_next = '0; asm_next = '0; skip_next = '0;
        end
    end

    assign q_data = pend_reg[pidx_reg];
    assign q_push = busy_reg && q_space;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FSPEC1;
            pres_reg <= '0; code_reg <= '0; item_reg <= '0; bii_reg <= '0;
            rep_reg <= '0; asm_reg <= '0; skip_reg <= '0;
            busy_reg <= 1'b0; pcnt_reg <= '0; pidx_reg <= '0;
        end else begin
            if (in_valid && in_ready) begin
                phase_reg <= phase_next;
                pres_reg <= pres_next; code_reg <= code_next; item_reg <= item_next;
                bii_reg <= bii_next; rep_reg <= rep_next; asm_reg <= asm_next;
                skip_reg <= skip_next;
                for (int r = 0; r < 6; r++) pend_reg[r] <= res[r];
                pcnt_reg <= cnt;
                pidx_reg <= '0;
                busy_reg <= (cnt != 3'd0);
            end else if (q_push) begin
                pidx_reg <= pidx_reg + 3'd1;
                if (pidx_reg + 3'd1 == pcnt_reg) busy_reg <= 1'b0;
            end
        end
    end

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> pidx_reg < pcnt_reg) else $error("drain index past count");
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready && busy_reg) |-> (q_push && (pidx_reg + 3'd1 == pcnt_reg)))
        else $error("accepted while draining");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pcnt_reg <= 3'd6) else $error("result count too large");

endmodule

// ----- sv/rvrp_queue.sv -----
module rvrp_queue
    import rvrp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    output logic    space,
    input  result_t push_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t    mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       pop;

    assign space     = cnt_reg != 3'd4;
    assign out_valid = cnt_reg != 3'd0;
    assign out_data  = mem_reg[rp_reg];
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, push} - {2'd0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 3'd4 |-> !push) else $error("queue overflow");

endmodule
